[sv/rlc_pkg.sv]
// Shared types, coefficients and the 2^x fraction table for the lux / CCT unit.
`default_nettype none
package rlc_pkg;

   // lux weights, Q12
   localparam logic [11:0] WR_LOW  = 12'd827;
   localparam logic [11:0] WG_LOW  = 12'd3138;
   localparam logic [11:0] WR_HIGH = 12'd651;
   localparam logic [11:0] WG_HIGH = 12'd2646;

   // blue weight gain, Q12
   localparam logic [15:0] KB_LOW  = 16'd12820;
   localparam logic [15:0] KB_HIGH = 16'd43704;
   // exponent slopes, base 2, Q12
   localparam logic [14:0] KR_LOW  = 15'd17202;
   localparam logic [14:0] KR_HIGH = 15'd16434;
   localparam logic [14:0] KE_LOW  = 15'd28749;
   localparam logic [14:0] KE_HIGH = 15'd26284;
   // blend amplitudes
   localparam logic [13:0] CA_LOW  = 14'd12746;
   localparam logic [13:0] CA_HIGH = 14'd16234;
   localparam logic [13:0] CB_LOW  = 14'd1637;
   localparam logic [13:0] CB_HIGH = 14'd1882;

   localparam logic [19:0] EXP_OFFSET = 20'd524288;   // 8.0 in Q16
   localparam logic [23:0] LUX_MAX    = 24'hFFFFFF;
   localparam logic [13:0] CCT_MAX    = 14'd10000;
   localparam logic [15:0] GLASS_RESET = 16'd16384;

   localparam logic [1:0] GAIN_2X  = 2'd1;
   localparam logic [1:0] GAIN_16X = 2'd2;

   typedef struct packed {
      logic [23:0] lux;
      logic        low_clear;
      logic        cct_ok;      // green and channel sum both nonzero
   } meta_type;

   // 2^(i/16) in Q16
   function automatic logic [16:0] pow2_frac(input logic [3:0] idx);
      logic [16:0] v;
      case (idx)
         4'd0:  v = 17'd65536;
         4'd1:  v = 17'd68438;
         4'd2:  v = 17'd71468;
         4'd3:  v = 17'd74632;
         4'd4:  v = 17'd77936;
         4'd5:  v = 17'd81386;
         4'd6:  v = 17'd84990;
         4'd7:  v = 17'd88752;
         4'd8:  v = 17'd92682;
         4'd9:  v = 17'd96785;
         4'd10: v = 17'd101070;
         4'd11: v = 17'd105545;
         4'd12: v = 17'd110218;
         4'd13: v = 17'd115098;
         4'd14: v = 17'd120194;
         4'd15: v = 17'd125515;
         default: v = 17'd65536;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

[sv/rlc_ratio_div.sv]
// Pipelined restoring divider: red and blue shares of the channel sum, one bit per stage.
`default_nettype none
module rlc_ratio_div #(
   parameter int RATIO_BITS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  en,
   input  wire logic [15:0]           red_in,
   input  wire logic [15:0]           blue_in,
   input  wire logic [17:0]           sum_in,
   output logic      [RATIO_BITS:0]   r_q,
   output logic      [RATIO_BITS:0]   b_q
);
   import rlc_pkg::*;

   logic [17:0]         rr_ff  [0:RATIO_BITS];
   logic [17:0]         br_ff  [0:RATIO_BITS];
   logic [RATIO_BITS:0] rq_ff  [0:RATIO_BITS];
   logic [RATIO_BITS:0] bq_ff  [0:RATIO_BITS];
   logic [17:0]         sum_ff [0:RATIO_BITS];

   logic r_top, b_top;
   assign r_top = {2'b00, red_in} >= sum_in;
   assign b_top = {2'b00, blue_in} >= sum_in;

   // count never exceeds sum, so the integer quotient is 0 or 1
   always_ff @(posedge clock) begin
      if (en) begin
         rr_ff[0]  <= r_top ? 18'({2'b00, red_in} - sum_in) : {2'b00, red_in};
         br_ff[0]  <= b_top ? 18'({2'b00, blue_in} - sum_in) : {2'b00, blue_in};
         rq_ff[0]  <= {{RATIO_BITS{1'b0}}, r_top};
         bq_ff[0]  <= {{RATIO_BITS{1'b0}}, b_top};
         sum_ff[0] <= sum_in;
      end
   end

   for (genvar j = 0; j < RATIO_BITS; j++) begin : g_step
      logic [18:0] rt, bt;
      logic        rbit, bbit;
      assign rt   = {rr_ff[j], 1'b0};
      assign bt   = {br_ff[j], 1'b0};
      assign rbit = rt >= {1'b0, sum_ff[j]};
      assign bbit = bt >= {1'b0, sum_ff[j]};
      always_ff @(posedge clock) begin
         if (en) begin
            rr_ff[j+1]  <= rbit ? 18'(rt - {1'b0, sum_ff[j]}) : rt[17:0];
            br_ff[j+1]  <= bbit ? 18'(bt - {1'b0, sum_ff[j]}) : bt[17:0];
            rq_ff[j+1]  <= {rq_ff[j][RATIO_BITS-1:0], rbit};
            bq_ff[j+1]  <= {bq_ff[j][RATIO_BITS-1:0], bbit};
            sum_ff[j+1] <= sum_ff[j];
         end
      end
   end

   assign r_q = rq_ff[RATIO_BITS];
   assign b_q = bq_ff[RATIO_BITS];

endmodule
`default_nettype wire

[sv/rlc_pow2.sv]
// Two-stage 2^(u - 8) unit in Q16: table lookup with linear interpolation, then shift.
`default_nettype none
module rlc_pow2 (
   input  wire logic        clock,
   input  wire logic        en,
   input  wire logic [19:0] u,
   output logic      [23:0] e
);
   import rlc_pkg::*;

   logic [3:0]  idx;
   logic [16:0] lo, hi;
   logic [12:0] diff;
   logic [24:0] prod_in;
   logic [24:0] prod_ff;
   logic [16:0] lo_ff;
   logic [3:0]  ip_ff;
   logic [16:0] mant;
   logic [31:0] shifted;
   logic [23:0] e_ff;

   assign idx     = u[15:12];
   assign lo      = pow2_frac(idx);
   assign hi      = (idx == 4'd15) ? 17'd0 : pow2_frac(4'(idx + 4'd1));
   // hi of the last entry is 131072, which wraps to 0 in 17 bits; the difference still fits
   assign diff    = 13'(hi - lo);
   assign prod_in = diff * u[11:0];

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
         lo_ff   <= lo;
         ip_ff   <= u[19:16];
      end
   end

   assign mant    = 17'(lo_ff + 17'(prod_ff >> 12));
   assign shifted = {15'd0, mant} << ip_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         e_ff <= shifted[31:8];
      end
   end

   assign e = e_ff;

endmodule
`default_nettype wire

[sv/rgbc_lux_cct_unit.sv]
// Top level: RGBC reading to illuminance and correlated color temperature.
// One item per cycle when the result side is ready; each item passes RATIO_BITS + 10
// register stages, most of them in the divider that produces one ratio bit per stage.
// A stalled result holds the whole pipeline. Lux goes through a 28x16 product and a
// shift by gain and integration time; CCT blends two base-2 exponentials of the red and
// blue ratios, clamped at 10000 K. csr_data writes the Q2.14 glass factor; write it only
// while no item is in flight.
`default_nettype none
module rgbc_lux_cct_unit #(
   parameter int RATIO_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // red_count[15:0], green_count[31:16], blue_count[47:32], clear_count[63:48],
   // gain_code[65:64], time_code[68:66], zero pad
   input  wire logic [71:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // lux_value[23:0], cct_kelvin[37:24], zero pad
   output logic      [39:0] rsp_tdata,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [15:0] csr_data
);
   import rlc_pkg::*;

   localparam int QW = RATIO_BITS + 1;
   localparam logic [QW-1:0] ONE = QW'(1) << RATIO_BITS;

   logic adv;
   logic [15:0] glass_ff;

   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv && !reset;
   assign csr_ready  = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         glass_ff <= GLASS_RESET;
      end else if (csr_valid) begin
         glass_ff <= csr_data;
      end
   end

   // stage 1: input register
   logic        v1_ff;
   logic [15:0] red1_ff, green1_ff, blue1_ff, clear1_ff;
   logic [1:0]  gain1_ff;
   logic [2:0]  time1_ff;

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (adv) v1_ff <= req_tvalid;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         red1_ff   <= req_tdata[15:0];
         green1_ff <= req_tdata[31:16];
         blue1_ff  <= req_tdata[47:32];
         clear1_ff <= req_tdata[63:48];
         gain1_ff  <= req_tdata[65:64];
         time1_ff  <= req_tdata[68:66];
      end
   end

   // stage 2: light type, weighted sum, channel sum, shift amount
   logic        low_clear_in;
   logic [2:0]  gshift_in;
   logic [27:0] w_in;
   logic        v2_ff, low2_ff, gnz2_ff;
   logic [27:0] w2_ff;
   logic [17:0] sum2_ff;
   logic [5:0]  shamt2_ff;
   logic [15:0] red2_ff, blue2_ff;

   assign low_clear_in = ({5'd0, clear1_ff} * 21'd25) < {3'd0, green1_ff, 2'b00};
   always_comb begin
      case (gain1_ff)
         GAIN_2X:  gshift_in = 3'd1;
         GAIN_16X: gshift_in = 3'd4;
         default:  gshift_in = 3'd0;
      endcase
   end
   assign w_in = low_clear_in ? 28'(red1_ff) * 28'(WR_LOW) + 28'(green1_ff) * 28'(WG_LOW)
                              : 28'(red1_ff) * 28'(WR_HIGH) + 28'(green1_ff) * 28'(WG_HIGH);

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (adv) v2_ff <= v1_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         low2_ff   <= low_clear_in;
         gnz2_ff   <= green1_ff != 16'd0;
         w2_ff     <= w_in;
         sum2_ff   <= 18'(red1_ff) + 18'(green1_ff) + 18'(blue1_ff);
         shamt2_ff <= 6'd22 + 6'(gshift_in) + 6'(time1_ff);
         red2_ff   <= red1_ff;
         blue2_ff  <= blue1_ff;
      end
   end

   // stage 3: lux product, parallel to divider setup
   logic        v3_ff, low3_ff, gnz3_ff, snz3_ff;
   logic [43:0] prod3_ff;
   logic [5:0]  shamt3_ff;

   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else if (adv) v3_ff <= v2_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         prod3_ff  <= w2_ff * glass_ff;
         shamt3_ff <= shamt2_ff;
         low3_ff   <= low2_ff;
         gnz3_ff   <= gnz2_ff;
         snz3_ff   <= sum2_ff != 18'd0;
      end
   end

   logic [QW-1:0] r_q, b_q;
   rlc_ratio_div #(.RATIO_BITS(RATIO_BITS)) u_div (
      .clock   (clock),
      .en      (adv),
      .red_in  (red2_ff),
      .blue_in (blue2_ff),
      .sum_in  (sum2_ff),
      .r_q     (r_q),
      .b_q     (b_q)
   );

   // lux finish, enters the delay line beside the divider
   logic [43:0] lux_full;
   meta_type    meta3;
   assign lux_full = prod3_ff >> shamt3_ff;
   always_comb begin
      meta3.low_clear = low3_ff;
      meta3.cct_ok    = gnz3_ff && snz3_ff;
      if (!gnz3_ff)             meta3.lux = 24'd0;
      else if (|lux_full[43:24]) meta3.lux = LUX_MAX;
      else                      meta3.lux = lux_full[23:0];
   end

   logic     dv_ff   [1:RATIO_BITS];
   meta_type dmeta_ff[1:RATIO_BITS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 1; k <= RATIO_BITS; k++) dv_ff[k] <= 1'b0;
      end else if (adv) begin
         dv_ff[1] <= v3_ff;
         for (int k = 2; k <= RATIO_BITS; k++) dv_ff[k] <= dv_ff[k-1];
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         dmeta_ff[1] <= meta3;
         for (int k = 2; k <= RATIO_BITS; k++) dmeta_ff[k] <= dmeta_ff[k-1];
      end
   end

   // E1: ratio products
   logic             v4_ff;
   meta_type         meta4_ff;
   logic [QW+15:0]   bk4_ff;
   logic [QW+14:0]   rk4_ff, be4_ff;
   logic             low_d;

   assign low_d = dmeta_ff[RATIO_BITS].low_clear;
   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else if (adv) v4_ff <= dv_ff[RATIO_BITS];
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         meta4_ff <= dmeta_ff[RATIO_BITS];
         bk4_ff   <= b_q * (low_d ? KB_LOW : KB_HIGH);
         rk4_ff   <= r_q * (low_d ? KR_LOW : KR_HIGH);
         be4_ff   <= b_q * (low_d ? KE_LOW : KE_HIGH);
      end
   end

   // E2: blue weight and exponent arguments
   logic [QW+3:0]  bw_full;
   logic [19:0]    m_in, n_in;
   logic           v5_ff;
   meta_type       meta5_ff;
   logic [QW-1:0]  beff5_ff;
   logic [19:0]    ur5_ff, ub5_ff;

   assign bw_full = bk4_ff[QW+15:12];
   assign m_in    = 20'(rk4_ff >> (RATIO_BITS - 4));
   assign n_in    = 20'(be4_ff >> (RATIO_BITS - 4));

   always_ff @(posedge clock) begin
      if (reset) v5_ff <= 1'b0;
      else if (adv) v5_ff <= v4_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         meta5_ff <= meta4_ff;
         beff5_ff <= (bw_full > (QW+4)'(ONE)) ? ONE : bw_full[QW-1:0];
         ur5_ff   <= EXP_OFFSET - m_in;
         ub5_ff   <= EXP_OFFSET + n_in;
      end
   end

   // E3, E4: exponentials
   logic [23:0] er, eb;
   rlc_pow2 u_pow_red  (.clock(clock), .en(adv), .u(ur5_ff), .e(er));
   rlc_pow2 u_pow_blue (.clock(clock), .en(adv), .u(ub5_ff), .e(eb));

   logic          v6_ff [0:1];
   meta_type      meta6_ff [0:1];
   logic [QW-1:0] beff6_ff [0:1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff[0] <= 1'b0;
         v6_ff[1] <= 1'b0;
      end else if (adv) begin
         v6_ff[0] <= v5_ff;
         v6_ff[1] <= v6_ff[0];
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         meta6_ff[0] <= meta5_ff;
         meta6_ff[1] <= meta6_ff[0];
         beff6_ff[0] <= beff5_ff;
         beff6_ff[1] <= beff6_ff[0];
      end
   end

   // E5: amplitude times exponential, red weight
   logic          v7_ff;
   meta_type      meta7_ff;
   logic [37:0]   t1_7_ff, t2_7_ff;
   logic [QW-1:0] w1_7_ff, beff7_ff;
   logic          low6;

   assign low6 = meta6_ff[1].low_clear;
   always_ff @(posedge clock) begin
      if (reset) v7_ff <= 1'b0;
      else if (adv) v7_ff <= v6_ff[1];
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         meta7_ff <= meta6_ff[1];
         t1_7_ff  <= er * (low6 ? CA_LOW : CA_HIGH);
         t2_7_ff  <= eb * (low6 ? CB_LOW : CB_HIGH);
         w1_7_ff  <= ONE - beff6_ff[1];
         beff7_ff <= beff6_ff[1];
      end
   end

   // E6: blend products
   logic             v8_ff;
   meta_type         meta8_ff;
   logic [QW+37:0]   p1_8_ff, p2_8_ff;

   always_ff @(posedge clock) begin
      if (reset) v8_ff <= 1'b0;
      else if (adv) v8_ff <= v7_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         meta8_ff <= meta7_ff;
         p1_8_ff  <= w1_7_ff * t1_7_ff;
         p2_8_ff  <= beff7_ff * t2_7_ff;
      end
   end

   // output register: sum, scale, clamp
   logic [QW+38:0] acc;
   logic [23:0]    cct_full;
   logic [13:0]    cct_in;
   logic           rsp_valid_ff;
   logic [23:0]    lux_ff;
   logic [13:0]    cct_ff;

   assign acc      = {1'b0, p1_8_ff} + {1'b0, p2_8_ff};
   assign cct_full = 24'(acc >> (RATIO_BITS + 16));
   assign cct_in   = !meta8_ff.cct_ok ? 14'd0
                   : (cct_full > 24'(CCT_MAX)) ? CCT_MAX : cct_full[13:0];

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (adv) rsp_valid_ff <= v8_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         lux_ff <= meta8_ff.lux;
         cct_ff <= cct_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, cct_ff, lux_ff};

`ifndef SYNTH
   a_cct_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[37:24] <= CCT_MAX))
      else $error("cct above clamp");

   a_cct_undefined: assert property (@(posedge clock) disable iff (reset)
      (adv && v8_ff && !meta8_ff.cct_ok) |=> (rsp_tdata[37:24] == 14'd0))
      else $error("cct nonzero for zero green or zero sum");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (!adv && v1_ff && v8_ff) |=> (v1_ff && v8_ff))
      else $error("pipeline item lost during stall");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");
`endif

endmodule
`default_nettype wire
